FILE: rtl/core/msd_pkg.sv
// Package: shared types and constants of the multibyte delimiter splitter.
package msd_pkg;

  localparam int MAX_DELIM  = 8;
  localparam int COUNT_BITS = 16;

  localparam int WIN_CAP    = (MAX_DELIM < 8) ? 8 : MAX_DELIM;
  localparam int DLEN_CAP   = (MAX_DELIM < 8) ? MAX_DELIM : 8;
  localparam int WIN_IDX_W  = $clog2(WIN_CAP);
  localparam int WIN_CNT_W  = WIN_IDX_W + 1;
  localparam int CNT_W      = (COUNT_BITS < 16) ? COUNT_BITS : 16;
  localparam int SEEN_W     = 4;
  localparam int SEEN_SAT   = 9;

  localparam int DELIM_W    = 64;
  localparam int DLEN_W     = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 1'd1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t in_byte;
    logic  final_byte;
  } msd_in_t;

  typedef struct packed {
    byte_t       out_byte;
    logic        byte_valid;
    logic        token_end;
    logic [15:0] piece_count;
    logic        started_with_delim;
    logic        ended_with_delim;
    logic        run_last;
  } msd_out_t;

endpackage

FILE: rtl/core/msd_if.sv
// Interfaces: input byte channel and result channel of the splitter.
interface msd_in_if import msd_pkg::*; ();
  logic    valid;
  logic    ready;
  msd_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface msd_out_if import msd_pkg::*; ();
  logic     valid;
  logic     ready;
  msd_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: rtl/core/multibyte_delimiter_splitter_top.sv
// Top level: splits a byte stream on a configurable 1 to 8 byte delimiter.
//
// Usage: bytes enter on text (valid/ready), one item per byte, final_byte on
// the last byte of a string. Results leave on tokens, one per cycle while
// ready: token bytes, piece closes, one closing item per string (run_last).
// The delimiter is set through cfg_we/cfg_index/cfg_data while idle.
//
// Order: a byte is registered on accept, processed into the result buffer
// once that buffer has drained, and its results are then offered from it.
// Throughput: one byte per cycle while each byte yields at most one result
// and tokens.ready is high. A byte with several results (flush of the held
// window at the end of a string, up to 9 results, or a shortened delimiter)
// holds the input until they leave; the result buffer drains one item per
// cycle while tokens.ready is high. Bytes yielding no result do not stall.
//
// Reset (rst, synchronous) empties the input register, result buffer and
// window, clears the per-string state and loads delimiter 0x00, length 1.
// A stalled receiver holds the current result; the input register then
// fills and text.ready drops until the buffer drains.
module multibyte_delimiter_splitter_top import msd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  msd_in_if.sink                text,
  msd_out_if.source             tokens
);

  // configuration
  logic [DELIM_W-1:0] delimiter_bytes;
  logic [DLEN_W-1:0]  delimiter_length;

  // input register
  logic    item_valid;
  msd_in_t item_q;

  // per-string state
  byte_t                match_window [WIN_CAP];
  logic [WIN_CNT_W-1:0] window_fill;
  logic [SEEN_W-1:0]    bytes_seen;
  logic                 token_open;
  logic [CNT_W-1:0]     pieces_found;
  logic                 start_match_flag;

  // result buffer
  byte_t                eb_bytes [WIN_CAP];
  logic [WIN_CNT_W-1:0] eb_cnt;
  logic [WIN_CNT_W-1:0] eb_idx;
  logic [CNT_W-1:0]     eb_base;
  logic                 tail_pend;
  msd_out_t             tail_item;

  // processing
  byte_t                wn [WIN_CAP];
  byte_t                sh [WIN_CAP];
  byte_t                window_next [WIN_CAP];
  logic [WIN_CNT_W-1:0] dlen;
  logic [WIN_CNT_W-1:0] wcnt;
  logic [WIN_CNT_W-1:0] surplus;
  logic [WIN_CNT_W-1:0] send_cnt;
  logic [SEEN_W-1:0]    seen_next;
  logic                 short_run;
  logic                 full;
  logic                 all_eq;
  logic                 match;
  logic                 fin;
  logic                 open_next;
  logic                 close_inc;
  logic                 tail_next;
  logic [CNT_W-1:0]     pieces_next;
  logic                 start_next;

  // handshake
  logic                 in_bytes;
  logic                 fire;
  logic                 last_fire;
  logic                 process;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_bytes  <= '0;
      delimiter_length <= DLEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELIM_BYTES:  delimiter_bytes  <= cfg_data[DELIM_W-1:0];
        REG_DELIM_LENGTH: delimiter_length <= cfg_data[DLEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (delimiter_length == '0) begin
      dlen = WIN_CNT_W'(1);
    end else if (delimiter_length > DLEN_W'(DLEN_CAP)) begin
      dlen = WIN_CNT_W'(DLEN_CAP);
    end else begin
      dlen = WIN_CNT_W'(delimiter_length);
    end
  end

  // output side
  assign in_bytes  = eb_idx < eb_cnt;
  assign tokens.valid = in_bytes || tail_pend;
  assign fire      = tokens.valid && tokens.ready;
  assign last_fire = fire && ((in_bytes && (eb_idx + WIN_CNT_W'(1) == eb_cnt) && !tail_pend)
                              || !in_bytes);
  assign process   = item_valid && (!tokens.valid || last_fire);
  assign text.ready = !item_valid || process;

  always_comb begin
    if (in_bytes) begin
      tokens.data                    = '0;
      tokens.data.out_byte           = eb_bytes[eb_idx[WIN_IDX_W-1:0]];
      tokens.data.byte_valid         = 1'b1;
      tokens.data.piece_count        = 16'(eb_base);
    end else begin
      tokens.data = tail_item;
    end
  end

  // window append, surplus and compare
  assign fin       = item_q.final_byte;
  assign wcnt      = window_fill + WIN_CNT_W'(1);
  assign seen_next = (bytes_seen < SEEN_W'(SEEN_SAT)) ? bytes_seen + SEEN_W'(1) : bytes_seen;
  assign short_run = fin && (seen_next <= SEEN_W'(dlen));
  assign surplus   = (wcnt > dlen) ? wcnt - dlen : '0;
  assign full      = wcnt >= dlen;

  always_comb begin : window_blk
    logic [WIN_CNT_W:0] t;
    all_eq = 1'b1;
    for (int i = 0; i < WIN_CAP; i++) begin
      if (WIN_CNT_W'(i) < window_fill) begin
        wn[i] = match_window[i];
      end else if (WIN_CNT_W'(i) == window_fill) begin
        wn[i] = item_q.in_byte;
      end else begin
        wn[i] = '0;
      end
    end
    for (int i = 0; i < WIN_CAP; i++) begin
      t = {1'b0, surplus} + (WIN_CNT_W+1)'(i);
      sh[i] = (t < (WIN_CNT_W+1)'(WIN_CAP)) ? wn[t[WIN_IDX_W-1:0]] : '0;
    end
    for (int i = 0; i < DLEN_CAP; i++) begin
      if ((WIN_CNT_W'(i) < dlen) && (sh[i] != delimiter_bytes[8*i +: 8])) begin
        all_eq = 1'b0;
      end
    end
  end

  always_comb begin : shift_blk
    logic [WIN_CNT_W:0] u;
    for (int i = 0; i < WIN_CAP; i++) begin
      u = {1'b0, send_cnt} + (WIN_CNT_W+1)'(i);
      window_next[i] = (u < (WIN_CNT_W+1)'(WIN_CAP)) ? wn[u[WIN_IDX_W-1:0]] : '0;
    end
  end

  assign match = !short_run && full && all_eq;

  always_comb begin
    priority if (short_run) begin
      send_cnt = wcnt;
    end else if (match) begin
      send_cnt = surplus;
    end else if (fin) begin
      send_cnt = wcnt;
    end else if (full) begin
      send_cnt = surplus + WIN_CNT_W'(1);
    end else begin
      send_cnt = '0;
    end
  end

  assign open_next   = token_open || (send_cnt != '0);
  assign close_inc   = open_next && (fin || match);
  assign tail_next   = fin || (match && open_next);
  assign pieces_next = (close_inc && (pieces_found != '1)) ? pieces_found + CNT_W'(1)
                                                           : pieces_found;
  assign start_next  = start_match_flag || (match && (seen_next == SEEN_W'(dlen)));

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text.ready) begin
      item_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      item_q <= text.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill      <= '0;
      bytes_seen       <= '0;
      token_open       <= 1'b0;
      pieces_found     <= '0;
      start_match_flag <= 1'b0;
    end else if (process) begin
      if (fin) begin
        window_fill      <= '0;
        bytes_seen       <= '0;
        token_open       <= 1'b0;
        pieces_found     <= '0;
        start_match_flag <= 1'b0;
      end else begin
        window_fill      <= match ? '0 : wcnt - send_cnt;
        bytes_seen       <= seen_next;
        token_open       <= match ? 1'b0 : open_next;
        pieces_found     <= pieces_next;
        start_match_flag <= start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      match_window <= window_next;
      eb_bytes     <= wn;
      eb_base      <= pieces_found;
      tail_item.out_byte           <= '0;
      tail_item.byte_valid         <= 1'b0;
      tail_item.token_end          <= open_next;
      tail_item.piece_count        <= 16'(pieces_next);
      tail_item.started_with_delim <= fin && !short_run && start_next;
      tail_item.ended_with_delim   <= fin && match;
      tail_item.run_last           <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eb_cnt    <= '0;
      eb_idx    <= '0;
      tail_pend <= 1'b0;
    end else if (process) begin
      eb_cnt    <= send_cnt;
      eb_idx    <= '0;
      tail_pend <= tail_next;
    end else if (fire) begin
      if (in_bytes) begin
        eb_idx <= eb_idx + WIN_CNT_W'(1);
      end else begin
        tail_pend <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) eb_idx <= eb_cnt)
    else $error("result index ran past byte count");

  assert property (@(posedge clk) disable iff (rst) window_fill < WIN_CNT_W'(WIN_CAP))
    else $error("match window overfilled");

  assert property (@(posedge clk) disable iff (rst)
    process && item_q.final_byte |=> window_fill == '0 && bytes_seen == '0
                                     && pieces_found == '0 && !token_open)
    else $error("string state not cleared after last byte");

  assert property (@(posedge clk) disable iff (rst)
    tokens.valid && tokens.data.run_last |-> !tokens.data.byte_valid)
    else $error("closing item carries a token byte");

endmodule
